>>> src/mvno_pkg.sv
// Shared types and constants for the mesh vertex normal offset unit.
// Used by every module of the block; depends on nothing else.
package mvno_pkg;

  localparam int VTX_COUNT = 1024;
  localparam int IDX_W     = $clog2(VTX_COUNT);
  localparam int COORD_W   = 24;
  localparam int SUM_W     = 64;
  localparam int THR_W     = 63;
  localparam int NRM_W     = 51;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int MUL_W     = 34;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TRI   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic [1:0]                action;
    logic [IDX_W-1:0]          vertex_index;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      degenerate_normal;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_distance;
    logic [THR_W-1:0]          normal_threshold;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

endpackage

>>> src/mvno_front.sv
// Front end: accepts transactions, drops unused actions and queues the rest.
// Depends on mvno_pkg.
module mvno_front import mvno_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output q_head_t  q_head,
  input  logic     q_pop
);

  in_item_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              accept, push, pop;

  assign in_stall = (count_r == (QPTR_W+1)'(QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_data.action inside {ACT_WRITE, ACT_TRI, ACT_QUERY});
  assign pop      = q_pop && (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> src/mvno_back.sv
// Back end: vertex and normal-sum memories, triangle accumulation and the
// offset query sequencer with a shared multiplier, root and divider steps.
// Depends on mvno_pkg.
module mvno_back import mvno_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_head_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_TRI_RD   = 17'b00000000000000010,
    S_TRI_EDGE = 17'b00000000000000100,
    S_TRI_MUL  = 17'b00000000000001000,
    S_TRI_NRD  = 17'b00000000000010000,
    S_TRI_NWR  = 17'b00000000000100000,
    S_Q_LOAD   = 17'b00000000001000000,
    S_Q_SQ     = 17'b00000000010000000,
    S_Q_CLS    = 17'b00000000100000000,
    S_Q_DMUL   = 17'b00000001000000000,
    S_Q_NORM   = 17'b00000010000000000,
    S_Q_SQ2    = 17'b00000100000000000,
    S_Q_SQRT   = 17'b00001000000000000,
    S_Q_DSET   = 17'b00010000000000000,
    S_Q_DIV    = 17'b00100000000000000,
    S_Q_LMUL   = 17'b01000000000000000,
    S_Q_OUT    = 17'b10000000000000000
  } state_t;

  localparam int POS_W = 3 * COORD_W;
  localparam int NS_W  = 3 * SUM_W;
  localparam int REM_W = 47;
  localparam int SQ_W  = 63;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] ci_r, ci_nxt;
  logic [3:0] dj_r, dj_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  // memories
  logic [POS_W-1:0] pos_mem [VTX_COUNT];
  logic [NS_W-1:0]  nrm_mem [VTX_COUNT];
  logic [POS_W-1:0] pos_rdata_r, pos_wdata;
  logic [NS_W-1:0]  nrm_rdata_r, nrm_wdata;
  logic [IDX_W-1:0] pos_raddr, pos_waddr, nrm_raddr, nrm_waddr;
  logic             pos_we, nrm_we;

  // datapath
  in_item_t                  cur_r;
  logic signed [COORD_W-1:0] tp_r [3][3];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [NRM_W-1:0]   n_r [3];
  logic signed [COORD_W-1:0] qp_r [3];
  logic                      qneg_r [3];
  logic [SUM_W-1:0]          qa_r [3];
  logic [65:0]               acc_r;
  logic [SUM_W-1:0]          m_r;
  logic [SQ_W-1:0]           sv_r, sr_r, bit_r;
  logic [31:0]               len_r;
  logic [REM_W-1:0]          rem_r;
  logic [15:0]               dq_r;
  logic signed [15:0]        u_r [3];
  logic signed [33:0]        d_r [3];
  logic                      degen_r;
  out_item_t                 out_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_r;

  logic [2:0]       kk;
  logic [IDX_W-1:0] corner_sel;
  logic             is_long;
  logic [SUM_W-1:0] m01, mmax;
  logic [SQ_W-1:0]  rt_sum, sv_step, sr_step;
  logic             rt_ge;
  logic [REM_W-1:0] trial;
  logic             dv_ge;
  logic [15:0]      q_step;
  logic [14:0]      uq;
  logic signed [15:0] u_val;
  logic signed [SUM_W:0] ns_sum [3];
  logic [SUM_W-1:0] ns_new [3];
  logic signed [34:0] o_sum [3];
  logic [COORD_W-1:0] o_val [3];
  logic [2:0]       o_sat;
  logic signed [2*MUL_W-1:0] rnd_d, rnd_l;

  assign kk = cnt_r - 3'd1;

  always_comb begin
    case (ci_r)
      2'd0:    corner_sel = cur_r.corner_a;
      2'd1:    corner_sel = cur_r.corner_b;
      default: corner_sel = cur_r.corner_c;
    endcase
  end

  // normal length class and largest component
  always_comb begin
    is_long = (qa_r[0][63:32] != '0) || (qa_r[1][63:32] != '0) || (qa_r[2][63:32] != '0)
           || (acc_r[65:64] != '0) || (acc_r[63:0] > {1'b0, cfg.normal_threshold});
    m01  = (qa_r[0] > qa_r[1]) ? qa_r[0] : qa_r[1];
    mmax = (m01 > qa_r[2]) ? m01 : qa_r[2];
  end

  // one step of the square root
  always_comb begin
    rt_sum  = sr_r + bit_r;
    rt_ge   = (sv_r >= rt_sum);
    sv_step = rt_ge ? sv_r - rt_sum : sv_r;
    sr_step = rt_ge ? (sr_r >> 1) + bit_r : (sr_r >> 1);
  end

  // one step of the restoring division
  always_comb begin
    trial  = REM_W'(len_r) << dj_r;
    dv_ge  = (rem_r >= trial);
    q_step = dq_r | (dv_ge ? (16'd1 << dj_r) : 16'd0);
    if (len_r == '0) begin
      uq = '0;
    end else if (q_step[15]) begin
      uq = 15'h7fff;
    end else begin
      uq = q_step[14:0];
    end
    u_val = qneg_r[ci_r] ? -$signed({1'b0, uq}) : $signed({1'b0, uq});
  end

  // saturating accumulation of the triangle normal into one corner's sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ns_sum[i] = $signed({nrm_rdata_r[i*SUM_W+SUM_W-1], nrm_rdata_r[i*SUM_W +: SUM_W]})
                + (SUM_W+1)'(n_r[i]);
      if (ns_sum[i][SUM_W] != ns_sum[i][SUM_W-1]) begin
        ns_new[i] = ns_sum[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        ns_new[i] = ns_sum[i][SUM_W-1:0];
      end
    end
  end

  // final position with clamping
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_sum[i] = 35'(qp_r[i]) + 35'(d_r[i]);
      if (!o_sum[i][34] && (o_sum[i][33:COORD_W-1] != '0)) begin
        o_val[i] = {1'b0, {(COORD_W-1){1'b1}}};
        o_sat[i] = 1'b1;
      end else if (o_sum[i][34] && (o_sum[i][33:COORD_W-1] != '1)) begin
        o_val[i] = {1'b1, {(COORD_W-1){1'b0}}};
        o_sat[i] = 1'b1;
      end else begin
        o_val[i] = o_sum[i][COORD_W-1:0];
        o_sat[i] = 1'b0;
      end
    end
  end

  assign rnd_d = mul_r + ((2*MUL_W)'(1) <<< 23);
  assign rnd_l = mul_r + ((2*MUL_W)'(1) <<< 14);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ci_nxt    = ci_r;
    dj_nxt    = dj_r;
    q_pop     = 1'b0;
    pos_we    = 1'b0;
    nrm_we    = 1'b0;
    pos_waddr = q_head.item.vertex_index;
    pos_wdata = {q_head.item.in_z, q_head.item.in_y, q_head.item.in_x};
    nrm_waddr = q_head.item.vertex_index;
    nrm_wdata = '0;
    pos_raddr = cur_r.corner_b;
    nrm_raddr = corner_sel;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          case (q_head.item.action)
            ACT_WRITE: begin
              pos_we = 1'b1;
              nrm_we = 1'b1;
            end
            ACT_TRI: begin
              pos_raddr = q_head.item.corner_a;
              cnt_nxt   = '0;
              state_nxt = S_TRI_RD;
            end
            ACT_QUERY: begin
              pos_raddr = q_head.item.vertex_index;
              nrm_raddr = q_head.item.vertex_index;
              state_nxt = S_Q_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_TRI_RD: begin
        pos_raddr = (cnt_r == 3'd0) ? cur_r.corner_b : cur_r.corner_c;
        if (cnt_r == 3'd2) begin
          state_nxt = S_TRI_EDGE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_TRI_EDGE: begin
        cnt_nxt   = '0;
        state_nxt = S_TRI_MUL;
      end
      S_TRI_MUL: begin
        case (cnt_r)
          3'd0: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
          3'd1: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
          3'd2: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
          3'd3: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
          3'd4: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
          3'd5: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
          default: ;
        endcase
        if (cnt_r == 3'd6) begin
          ci_nxt    = '0;
          state_nxt = S_TRI_NRD;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_TRI_NRD: begin
        state_nxt = S_TRI_NWR;
      end
      S_TRI_NWR: begin
        nrm_we    = 1'b1;
        nrm_waddr = corner_sel;
        nrm_wdata = {ns_new[2], ns_new[1], ns_new[0]};
        if (ci_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = S_TRI_NRD;
        end
      end
      S_Q_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_Q_SQ;
      end
      S_Q_SQ, S_Q_SQ2: begin
        if (cnt_r != 3'd3) begin
          mul_a = $signed({2'b00, qa_r[cnt_r[1:0]][31:0]});
          mul_b = $signed({2'b00, qa_r[cnt_r[1:0]][31:0]});
          cnt_nxt = cnt_r + 3'd1;
        end else begin
          state_nxt = (state_r == S_Q_SQ) ? S_Q_CLS : S_Q_SQRT;
        end
      end
      S_Q_CLS: begin
        cnt_nxt   = '0;
        state_nxt = is_long ? S_Q_NORM : S_Q_DMUL;
      end
      S_Q_NORM: begin
        if (m_r[63:30] == '0) begin
          cnt_nxt   = '0;
          state_nxt = S_Q_SQ2;
        end
      end
      S_Q_SQRT: begin
        if (bit_r[0]) begin
          ci_nxt    = '0;
          state_nxt = S_Q_DSET;
        end
      end
      S_Q_DSET: begin
        dj_nxt    = 4'd15;
        state_nxt = S_Q_DIV;
      end
      S_Q_DIV: begin
        dj_nxt = dj_r - 4'd1;
        if (dj_r == 4'd0) begin
          if (ci_r == 2'd2) begin
            cnt_nxt   = '0;
            state_nxt = S_Q_LMUL;
          end else begin
            ci_nxt    = ci_r + 2'd1;
            state_nxt = S_Q_DSET;
          end
        end
      end
      S_Q_DMUL: begin
        if (cnt_r != 3'd3) begin
          mul_a = MUL_W'(cfg.offset_distance);
          mul_b = qneg_r[cnt_r[1:0]] ? -$signed({2'b00, qa_r[cnt_r[1:0]][31:0]})
                                     : $signed({2'b00, qa_r[cnt_r[1:0]][31:0]});
          cnt_nxt = cnt_r + 3'd1;
        end else begin
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_LMUL: begin
        if (cnt_r != 3'd3) begin
          mul_a   = MUL_W'(cfg.offset_distance);
          mul_b   = MUL_W'(u_r[cnt_r[1:0]]);
          cnt_nxt = cnt_r + 3'd1;
        end else begin
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ci_r        <= '0;
      dj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ci_r        <= ci_nxt;
      dj_r        <= dj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    nrm_rdata_r <= nrm_mem[nrm_raddr];
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          cur_r <= q_head.item;
        end
      end
      S_TRI_RD: begin
        for (int i = 0; i < 3; i++) begin
          tp_r[cnt_r[1:0]][i] <= pos_rdata_r[i*COORD_W +: COORD_W];
        end
      end
      S_TRI_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= EDGE_W'(tp_r[1][i]) - EDGE_W'(tp_r[0][i]);
          e2_r[i] <= EDGE_W'(tp_r[2][i]) - EDGE_W'(tp_r[0][i]);
        end
      end
      S_TRI_MUL: begin
        if (cnt_r != 3'd0) begin
          if (!kk[0]) begin
            n_r[kk[2:1]] <= $signed(mul_r[NRM_W-1:0]);
          end else begin
            n_r[kk[2:1]] <= n_r[kk[2:1]] - $signed(mul_r[NRM_W-1:0]);
          end
        end
      end
      S_Q_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          qp_r[i]   <= pos_rdata_r[i*COORD_W +: COORD_W];
          qneg_r[i] <= nrm_rdata_r[i*SUM_W + SUM_W - 1];
          qa_r[i]   <= nrm_rdata_r[i*SUM_W + SUM_W - 1] ? (~nrm_rdata_r[i*SUM_W +: SUM_W]) + 1'b1
                                                        : nrm_rdata_r[i*SUM_W +: SUM_W];
        end
        acc_r <= '0;
      end
      S_Q_SQ, S_Q_SQ2: begin
        if (cnt_r != 3'd0) begin
          acc_r <= acc_r + 66'(mul_r[63:0]);
        end
        if (cnt_r == 3'd3) begin
          sv_r  <= SQ_W'(acc_r + 66'(mul_r[63:0]));
          sr_r  <= '0;
          bit_r <= SQ_W'(1) << (SQ_W - 1);
        end
      end
      S_Q_CLS: begin
        m_r     <= mmax;
        degen_r <= !is_long;
        // The scaled components are summed afresh for the root.
        acc_r   <= '0;
      end
      S_Q_NORM: begin
        if (m_r[63:30] != '0) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) begin
            qa_r[i] <= qa_r[i] >> 1;
          end
        end
      end
      S_Q_SQRT: begin
        sv_r  <= sv_step;
        sr_r  <= sr_step;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= sr_step[31:0];
        end
      end
      S_Q_DSET: begin
        rem_r <= REM_W'({qa_r[ci_r][29:0], 15'd0}) + REM_W'(len_r >> 1);
        dq_r  <= '0;
      end
      S_Q_DIV: begin
        if (dv_ge) begin
          rem_r <= rem_r - trial;
        end
        dq_r <= q_step;
        if (dj_r == 4'd0) begin
          u_r[ci_r] <= u_val;
        end
      end
      S_Q_DMUL: begin
        if (cnt_r != 3'd0) begin
          d_r[kk[1:0]] <= 34'(rnd_d >>> 24);
        end
      end
      S_Q_LMUL: begin
        if (cnt_r != 3'd0) begin
          d_r[kk[1:0]] <= 34'(rnd_l >>> 15);
        end
      end
      S_Q_OUT: begin
        if (out_load) begin
          out_r.out_index         <= cur_r.vertex_index;
          out_r.out_x             <= o_val[0];
          out_r.out_y             <= o_val[1];
          out_r.out_z             <= o_val[2];
          out_r.degenerate_normal <= degen_r;
          out_r.saturated         <= |o_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/mesh_vertex_normal_offset_unit.sv
// Top level of the mesh vertex normal offset unit: configuration registers,
// front-end queue and back-end sequencer. Depends on mvno_pkg, mvno_front, mvno_back.
//
// The unit keeps 1024 vertex positions (signed Q11.12) and, per vertex, a
// saturating 64-bit sum of the area-weighted normals of the triangles that
// touch it. A write-vertex transaction stores a position and clears its sum;
// an add-triangle transaction adds (B-A) x (C-A) to the sums of all three
// corners; a query transaction returns the vertex moved by the offset
// distance along its unit normal, or along the raw sum (flagged) when the
// squared length does not exceed the threshold. Positions and sums that were
// never written read as undefined. The front end takes up to four
// transactions into a queue while the back end works, so input is taken
// even while a result waits on the output register. In the back end a triangle
// takes three position reads, six products through the single shared
// multiplier, then three read-modify-write passes on the normal memory; a
// query with a long normal adds the bit-at-a-time scaling shift, the 32-step
// square root and three 16-step divisions. Configuration sits on an APB-style
// port with 64-bit data: offset distance at byte address 0 and threshold at 8.
module mesh_vertex_normal_offset_unit import mvno_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic signed [COORD_W-1:0] offset_r, offset_nxt;
  logic [THR_W-1:0]          thresh_r, thresh_nxt;
  logic                      cfg_wr;
  cfg_t                      cfg;
  q_head_t                   q_head;
  logic                      q_pop;

  // The register is chosen by bit 3 of the byte address; the lower bits
  // select nothing further.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    offset_nxt = offset_r;
    thresh_nxt = thresh_r;
    if (cfg_wr) begin
      if (paddr[3] == REG_OFFSET) begin
        offset_nxt = pwdata[COORD_W-1:0];
      end else begin
        thresh_nxt = pwdata[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      thresh_r <= THR_W'(1);
    end else begin
      offset_r <= offset_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  // Reads return the offset sign-extended and the threshold zero-extended.
  assign prdata = (paddr[3] == REG_THRESH) ? {1'b0, thresh_r} : 64'(offset_r);

  assign cfg.offset_distance  = offset_r;
  assign cfg.normal_threshold = thresh_r;

  // The front end drops the unused action code, so it causes no work at all.
  mvno_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // The back end owns both memories and delivers one result per query.
  mvno_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/mesh_vertex_normal_offset_unit_tb.sv
// Self-checking testbench for the mesh vertex normal offset unit.
// Drives vertex, triangle and query transactions against an in-bench
// predictor; depends on mvno_pkg and the mesh_vertex_normal_offset_unit RTL.
`timescale 1ns / 1ps

module mesh_vertex_normal_offset_unit_tb;
  import mvno_pkg::*;

  localparam longint COORD_MAX = 64'sd8388607;
  localparam longint COORD_MIN = -64'sd8388608;
  localparam logic [3:0] ADDR_OFFSET = 4'd0;
  localparam logic [3:0] ADDR_THRESH = 4'd8;
  localparam logic [62:0] THRESH_MAX = {63{1'b1}};
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  mesh_vertex_normal_offset_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the vertex table, the normal sums and both registers.
  longint      pos_x [VTX_COUNT];
  longint      pos_y [VTX_COUNT];
  longint      pos_z [VTX_COUNT];
  longint      nsum_x [VTX_COUNT];
  longint      nsum_y [VTX_COUNT];
  longint      nsum_z [VTX_COUNT];
  bit          is_written [VTX_COUNT];
  int          written_list [$];
  longint      offset_reg;
  logic [62:0] thresh_reg;

  out_item_t   expected_offsets [$];
  int          error_count;
  int          burst_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor arithmetic
  // ---------------------------------------------------------------------------

  // Signed 64-bit addition that clamps instead of wrapping.
  function automatic longint add_sat64(input longint a, input longint b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    logic [63:0] u;
    u = v;
    return v < 0 ? ~u + 64'd1 : u;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // True when the normal sum is long enough to be normalised.
  function automatic bit normal_is_long(input longint s [3]);
    logic [65:0] acc;
    logic [63:0] a;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      a = magnitude(s[i]);
      if (a >= (64'd1 << 32)) return 1'b1;
      acc = acc + a * a;
    end
    if (acc > {2'b00, {64{1'b1}}}) return 1'b1;
    return acc[63:0] > {1'b0, thresh_reg};
  endfunction

  // Updates the shadow state for one accepted transaction and queues the
  // expected result of a query.
  task automatic predict_offset_vertex(input in_item_t it);
    int          ca, cb, cc, vi;
    longint      e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    longint      s [3];
    longint      p [3];
    longint      d [3];
    longint      r;
    longint      u;
    logic [63:0] a [3];
    logic [63:0] m, sq, len, q;
    int          k;
    bit          degen, sat;
    out_item_t   res;
    vi = it.vertex_index;
    case (it.action)
      ACT_WRITE: begin
        pos_x[vi] = it.in_x;
        pos_y[vi] = it.in_y;
        pos_z[vi] = it.in_z;
        nsum_x[vi] = 0;
        nsum_y[vi] = 0;
        nsum_z[vi] = 0;
      end
      ACT_TRI: begin
        ca = it.corner_a;
        cb = it.corner_b;
        cc = it.corner_c;
        e1x = pos_x[cb] - pos_x[ca];
        e1y = pos_y[cb] - pos_y[ca];
        e1z = pos_z[cb] - pos_z[ca];
        e2x = pos_x[cc] - pos_x[ca];
        e2y = pos_y[cc] - pos_y[ca];
        e2z = pos_z[cc] - pos_z[ca];
        // Edge products stay well inside 64 bits, so only the sums can clamp.
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        foreach (p[i]) begin
          k = (i == 0) ? ca : (i == 1) ? cb : cc;
          nsum_x[k] = add_sat64(nsum_x[k], nx);
          nsum_y[k] = add_sat64(nsum_y[k], ny);
          nsum_z[k] = add_sat64(nsum_z[k], nz);
        end
      end
      ACT_QUERY: begin
        s[0] = nsum_x[vi]; s[1] = nsum_y[vi]; s[2] = nsum_z[vi];
        p[0] = pos_x[vi];  p[1] = pos_y[vi];  p[2] = pos_z[vi];
        degen = !normal_is_long(s);
        sat = 1'b0;
        if (degen) begin
          for (int i = 0; i < 3; i++) d[i] = (offset_reg * s[i] + (64'sd1 <<< 23)) >>> 24;
        end else begin
          m = 0;
          for (int i = 0; i < 3; i++) begin
            a[i] = magnitude(s[i]);
            if (a[i] > m) m = a[i];
          end
          k = 0;
          while ((m >> k) >= (64'd1 << 30)) k++;
          sq = 0;
          for (int i = 0; i < 3; i++) begin
            a[i] = a[i] >> k;
            sq = sq + a[i] * a[i];
          end
          len = int_sqrt(sq);
          for (int i = 0; i < 3; i++) begin
            u = 0;
            if (len != 0) begin
              q = ((a[i] << 15) + (len >> 1)) / len;
              if (q > 64'd32767) q = 64'd32767;
              u = s[i] < 0 ? -longint'(q) : longint'(q);
            end
            d[i] = (offset_reg * u + 64'sd16384) >>> 15;
          end
        end
        for (int i = 0; i < 3; i++) begin
          r = p[i] + d[i];
          if (r > COORD_MAX) begin
            r = COORD_MAX;
            sat = 1'b1;
          end
          if (r < COORD_MIN) begin
            r = COORD_MIN;
            sat = 1'b1;
          end
          p[i] = r;
        end
        res.out_index = it.vertex_index;
        res.out_x = p[0][COORD_W-1:0];
        res.out_y = p[1][COORD_W-1:0];
        res.out_z = p[2][COORD_W-1:0];
        res.degenerate_normal = degen;
        res.saturated = sat;
        expected_offsets.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_offsets.size() == 0) begin
        report($sformatf("unexpected result for vertex %0d", out_data.out_index));
      end else begin
        want = expected_offsets.pop_front();
        if (out_data.out_index != want.out_index)
          report($sformatf("index got %0d want %0d", out_data.out_index, want.out_index));
        if (out_data.out_x != want.out_x)
          report($sformatf("vertex %0d x got %0d want %0d", want.out_index,
                           out_data.out_x, want.out_x));
        if (out_data.out_y != want.out_y)
          report($sformatf("vertex %0d y got %0d want %0d", want.out_index,
                           out_data.out_y, want.out_y));
        if (out_data.out_z != want.out_z)
          report($sformatf("vertex %0d z got %0d want %0d", want.out_index,
                           out_data.out_z, want.out_z));
        if (out_data.degenerate_normal != want.degenerate_normal)
          report($sformatf("vertex %0d degenerate flag got %0b want %0b", want.out_index,
                           out_data.degenerate_normal, want.degenerate_normal));
        if (out_data.saturated != want.saturated)
          report($sformatf("vertex %0d saturation flag got %0b want %0b", want.out_index,
                           out_data.saturated, want.saturated));
      end
    end
  end

  // The receiver cycles through calm, patchy and heavy stall phases so that
  // back-pressure lands on the back end's output register.
  int stall_mode;
  int stall_phase_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      stall_phase_left <= 50;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode <= $urandom_range(2);
        stall_phase_left <= $urandom_range(300, 20);
      end else begin
        stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(99) < 30);
        default: out_stall <= ($urandom_range(99) < 80);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random filler for the fields that the chosen action does not use.
  function automatic in_item_t random_item();
    in_item_t     it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // Presents one transaction and holds it until it is taken. Stall only moves
  // on a rising edge, so it is looked at mid-cycle.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_offset_vertex(it);
    if (it.action == ACT_WRITE && !is_written[it.vertex_index]) begin
      is_written[it.vertex_index] = 1'b1;
      written_list.push_back(it.vertex_index);
    end
    // Bursts of random length, separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  endtask

  task automatic write_vertex(input int vi, input longint x, input longint y, input longint z);
    in_item_t it;
    it = random_item();
    it.action = ACT_WRITE;
    it.vertex_index = IDX_W'(vi);
    it.in_x = x[COORD_W-1:0];
    it.in_y = y[COORD_W-1:0];
    it.in_z = z[COORD_W-1:0];
    send_item(it);
  endtask

  task automatic add_triangle(input int a, input int b, input int c);
    in_item_t it;
    it = random_item();
    it.action = ACT_TRI;
    it.corner_a = IDX_W'(a);
    it.corner_b = IDX_W'(b);
    it.corner_c = IDX_W'(c);
    send_item(it);
  endtask

  task automatic query_vertex(input int vi);
    in_item_t it;
    it = random_item();
    it.action = ACT_QUERY;
    it.vertex_index = IDX_W'(vi);
    send_item(it);
  endtask

  // Waits until every expected result has been checked, then lets the back
  // end finish any triangle still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_offsets.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // APB write with setup and access phases; the register takes the data on the access edge.
  task automatic cfg_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_OFFSET) offset_reg = longint'(signed'(data[COORD_W-1:0]));
    else thresh_reg = data[62:0];
  endtask

  task automatic set_config(input longint offset, input logic [62:0] thresh);
    drain();
    cfg_write(ADDR_OFFSET, offset);
    cfg_write(ADDR_THRESH, {1'b0, thresh});
  endtask

  function automatic longint random_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1, 0) ? COORD_MAX : COORD_MIN;
      1: return longint'(signed'(24'($urandom)));
      default: return longint'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme positions with cleared normals: the zero-length normal always
  // takes the raw path, so the position comes back unchanged.
  task automatic test_vertex_extremes();
    set_config(COORD_MAX, 63'd1);
    write_vertex(0, COORD_MAX, COORD_MAX, COORD_MAX);
    write_vertex(VTX_COUNT - 1, COORD_MIN, COORD_MIN, COORD_MIN);
    write_vertex(512, 0, -1, 1);
    query_vertex(0);
    query_vertex(VTX_COUNT - 1);
    query_vertex(512);
  endtask

  // Large triangles give long normals that push coordinates into saturation;
  // a triangle with a repeated corner adds nothing; an unused action is
  // simply dropped.
  task automatic test_triangle_normals();
    in_item_t it;
    write_vertex(1, COORD_MAX, COORD_MIN, 0);
    write_vertex(2, COORD_MIN, COORD_MAX, COORD_MAX);
    write_vertex(3, 0, COORD_MAX, COORD_MIN);
    add_triangle(1, 2, 3);
    add_triangle(3, 2, 1);
    add_triangle(1, 2, 3);
    add_triangle(1, 1, 2);
    query_vertex(1);
    query_vertex(2);
    it = random_item();
    it.action = ACT_UNUSED;
    send_item(it);
    query_vertex(3);
    set_config(COORD_MIN, 63'd1);
    query_vertex(1);
    query_vertex(2);
  endtask

  // A threshold of zero normalises every non-zero sum; the largest one makes
  // every bounded sum take the raw path.
  task automatic test_threshold_extremes();
    set_config(64'sd4096, 63'd0);
    write_vertex(10, 0, 0, 0);
    write_vertex(11, 1, 0, 0);
    write_vertex(12, 0, 1, 0);
    add_triangle(10, 11, 12);
    query_vertex(10);
    set_config(-64'sd4096, THRESH_MAX);
    query_vertex(10);
    query_vertex(1);
  endtask

  // Mostly well-formed mesh traffic over written vertices, with some unused
  // actions mixed in, and periodic register changes once the unit is idle.
  task automatic test_random_mesh();
    int sent;
    int pick;
    in_item_t it;
    sent = 0;
    while (sent < 450) begin
      if (sent % 120 == 119) begin
        set_config(random_coord(),
                   $urandom_range(1) ? 63'($urandom_range(1 << 20)) :
                                       63'({$urandom, $urandom}));
        sent++;
      end
      pick = $urandom_range(99);
      if (pick < 25 || written_list.size() < 3) begin
        write_vertex($urandom_range(VTX_COUNT - 1), random_coord(), random_coord(),
                     random_coord());
        sent++;
      end else if (pick < 60) begin
        add_triangle(written_list[$urandom_range(written_list.size() - 1)],
                     written_list[$urandom_range(written_list.size() - 1)],
                     written_list[$urandom_range(written_list.size() - 1)]);
        sent++;
      end else if (pick < 92) begin
        query_vertex(written_list[$urandom_range(written_list.size() - 1)]);
        sent++;
      end else begin
        it = random_item();
        it.action = ACT_UNUSED;
        send_item(it);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    error_count = 0;
    burst_left  = 0;
    offset_reg  = 0;
    thresh_reg  = 63'd1;
    foreach (is_written[i]) is_written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_vertex_extremes();
    test_triangle_normals();
    test_threshold_extremes();
    test_random_mesh();

    drain();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
